/* sv/led_chain_bit_serializer_unit_defines.svh */
// Assertion helpers for the serializer modules; the engine (lcbs_back) uses them.
`ifndef LED_CHAIN_BIT_SERIALIZER_UNIT_DEFINES_SVH
`define LED_CHAIN_BIT_SERIALIZER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCBS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lcbs same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LCBS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lcbs next-cycle check failed");

`endif

/* sv/lcbs_pkg.sv */
package lcbs_pkg;

    localparam int unsigned CfgIndexBits = 3;

    // Configuration register indexes.
    typedef enum logic [CfgIndexBits-1:0] {
        REG_SPEED_MODE     = 3'd0,
        REG_FAST_ONE_HIGH  = 3'd1,
        REG_FAST_ONE_LOW   = 3'd2,
        REG_FAST_ZERO_HIGH = 3'd3,
        REG_FAST_ZERO_LOW  = 3'd4,
        REG_TICKS_PER_US   = 3'd5
    } cfg_reg_t;

    // Item kinds.
    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [7:0] MSB_MASK = 8'h80;
    localparam logic [2:0] LAST_BIT_COUNT = 3'd7;

    typedef struct packed {
        logic       kind;
        logic [7:0] data_byte;
        logic       final_byte;
    } item_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
        logic holder_free;
        logic load_dropped;
        logic frame_done;
    } result_t;

    // Item as classified by the front end.
    typedef struct packed {
        logic       is_tick;
        logic [7:0] data_byte;
        logic       final_byte;
    } work_t;

endpackage

/* sv/lcbs_cfg.sv */
module lcbs_cfg #(
    parameter int unsigned TIMING_BITS = 10
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [lcbs_pkg::CfgIndexBits-1:0]      cfg_index,
    input  logic [TIMING_BITS-1:0]                 cfg_data,
    output logic                                   speed_mode,
    output logic [TIMING_BITS-1:0]                 fast_one_high,
    output logic [TIMING_BITS-1:0]                 fast_one_low,
    output logic [TIMING_BITS-1:0]                 fast_zero_high,
    output logic [TIMING_BITS-1:0]                 fast_zero_low,
    output logic [TIMING_BITS-1:0]                 ticks_per_us
);

    logic                   speed_mode_reg;
    logic [TIMING_BITS-1:0] one_high_reg;
    logic [TIMING_BITS-1:0] one_low_reg;
    logic [TIMING_BITS-1:0] zero_high_reg;
    logic [TIMING_BITS-1:0] zero_low_reg;
    logic [TIMING_BITS-1:0] tpu_reg;

    // Reset values are cut to the timing width, as the hardware keeps only that many bits.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_mode_reg <= 1'b1;
            one_high_reg   <= TIMING_BITS'(140);
            one_low_reg    <= TIMING_BITS'(68);
            zero_high_reg  <= TIMING_BITS'(68);
            zero_low_reg   <= TIMING_BITS'(140);
            tpu_reg        <= TIMING_BITS'(168);
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                lcbs_pkg::REG_SPEED_MODE:     speed_mode_reg <= cfg_data[0];
                lcbs_pkg::REG_FAST_ONE_HIGH:  one_high_reg   <= cfg_data;
                lcbs_pkg::REG_FAST_ONE_LOW:   one_low_reg    <= cfg_data;
                lcbs_pkg::REG_FAST_ZERO_HIGH: zero_high_reg  <= cfg_data;
                lcbs_pkg::REG_FAST_ZERO_LOW:  zero_low_reg   <= cfg_data;
                lcbs_pkg::REG_TICKS_PER_US:   tpu_reg        <= cfg_data;
                default:                      ;
            endcase
        end
    end

    assign speed_mode     = speed_mode_reg;
    assign fast_one_high  = one_high_reg;
    assign fast_one_low   = one_low_reg;
    assign fast_zero_high = zero_high_reg;
    assign fast_zero_low  = zero_low_reg;
    assign ticks_per_us   = tpu_reg;

endmodule

/* sv/lcbs_front.sv */
module lcbs_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  lcbs_pkg::item_t     item,
    output lcbs_pkg::work_t     work,
    input  logic                work_take,
    output logic                work_avail
);

    lcbs_pkg::work_t slot_reg [2];
    logic [1:0]      cnt_reg, cnt_next;
    logic            wr_reg, rd_reg;
    logic            do_push, do_pop;

    assign full       = (cnt_reg == 2'd2);
    assign work_avail = (cnt_reg != 2'd0);
    assign do_push    = push && !full;
    assign do_pop     = work_take && work_avail;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 2'd1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wr_reg  <= 1'b0;
            rd_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_reg <= !wr_reg;
            end
            if (do_pop)
            begin
                rd_reg <= !rd_reg;
            end
        end
    end

    // Items are classified on entry so the engine sees a tick flag.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_reg].is_tick    <= (item.kind == lcbs_pkg::KIND_TICK);
            slot_reg[wr_reg].data_byte  <= item.data_byte;
            slot_reg[wr_reg].final_byte <= item.final_byte;
        end
    end

    assign work = slot_reg[rd_reg];

endmodule

/* sv/lcbs_back.sv */
`include "led_chain_bit_serializer_unit_defines.svh"

module lcbs_back #(
    parameter int unsigned TIMING_BITS = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  lcbs_pkg::work_t        work,
    input  logic                   work_avail,
    output logic                   work_take,
    input  logic                   speed_mode,
    input  logic [TIMING_BITS-1:0] fast_one_high,
    input  logic [TIMING_BITS-1:0] fast_one_low,
    input  logic [TIMING_BITS-1:0] fast_zero_high,
    input  logic [TIMING_BITS-1:0] fast_zero_low,
    input  logic [TIMING_BITS-1:0] ticks_per_us,
    output logic                   empty,
    input  logic                   pop,
    output lcbs_pkg::result_t      result
);

    localparam int unsigned PhaseBits = TIMING_BITS + 1;

    logic [7:0]           held_byte_reg,  held_byte_next;
    logic                 held_valid_reg, held_valid_next;
    logic                 held_final_reg, held_final_next;
    logic [7:0]           shift_reg,      shift_next;
    logic [2:0]           bits_reg,       bits_next;
    logic                 high_reg,       high_next;
    logic [PhaseBits-1:0] phase_reg,      phase_next;
    logic                 sending_reg,    sending_next;
    logic                 sfinal_reg,     sfinal_next;

    logic                 dropped, done;
    logic                 pl_high, pl_one;
    logic [PhaseBits-1:0] pl_raw, pl_len;

    lcbs_pkg::result_t    res;
    lcbs_pkg::result_t    out_reg [2];
    logic [1:0]           out_cnt_reg, out_cnt_next;
    logic                 out_wr_reg, out_rd_reg;
    logic                 out_pop;

    assign out_pop   = pop && !empty;
    assign empty     = (out_cnt_reg == 2'd0);
    assign work_take = work_avail && ((out_cnt_reg != 2'd2) || out_pop);

    // Length of the phase being started; zero counts as one tick.
    always_comb
    begin
        if (speed_mode)
        begin
            if (pl_high)
            begin
                pl_raw = PhaseBits'(pl_one ? fast_one_high : fast_zero_high);
            end
            else
            begin
                pl_raw = PhaseBits'(pl_one ? fast_one_low : fast_zero_low);
            end
        end
        else if (pl_high || pl_one)
        begin
            pl_raw = PhaseBits'(ticks_per_us);
        end
        else
        begin
            pl_raw = {ticks_per_us, 1'b0};
        end
        pl_len = (pl_raw == '0) ? PhaseBits'(1) : pl_raw;
    end

    always_comb
    begin
        held_byte_next  = held_byte_reg;
        held_valid_next = held_valid_reg;
        held_final_next = held_final_reg;
        shift_next      = shift_reg;
        bits_next       = bits_reg;
        high_next       = high_reg;
        phase_next      = phase_reg;
        sending_next    = sending_reg;
        sfinal_next     = sfinal_reg;
        dropped         = 1'b0;
        done            = 1'b0;
        pl_high         = 1'b1;
        pl_one          = held_byte_reg[7];

        if (!work.is_tick)
        begin
            if (held_valid_reg)
            begin
                dropped = 1'b1;
            end
            else
            begin
                held_byte_next  = work.data_byte;
                held_final_next = work.final_byte;
                held_valid_next = 1'b1;
            end
        end
        else if (!sending_reg)
        begin
            if (held_valid_reg)
            begin
                shift_next      = held_byte_reg;
                sfinal_next     = held_final_reg;
                held_valid_next = 1'b0;
                bits_next       = lcbs_pkg::LAST_BIT_COUNT;
                sending_next    = 1'b1;
                high_next       = 1'b1;
                phase_next      = pl_len;
            end
        end
        else if (phase_reg > PhaseBits'(1))
        begin
            phase_next = phase_reg - PhaseBits'(1);
        end
        else if (high_reg)
        begin
            pl_high    = 1'b0;
            pl_one     = |(shift_reg & lcbs_pkg::MSB_MASK);
            high_next  = 1'b0;
            phase_next = pl_len;
        end
        else if (bits_reg != 3'd0)
        begin
            pl_one     = shift_reg[6];
            bits_next  = bits_reg - 3'd1;
            shift_next = {shift_reg[6:0], 1'b0};
            high_next  = 1'b1;
            phase_next = pl_len;
        end
        else
        begin
            done = sfinal_reg;
            if (held_valid_reg)
            begin
                shift_next      = held_byte_reg;
                sfinal_next     = held_final_reg;
                held_valid_next = 1'b0;
                bits_next       = lcbs_pkg::LAST_BIT_COUNT;
                high_next       = 1'b1;
                phase_next      = pl_len;
            end
            else
            begin
                sending_next = 1'b0;
                sfinal_next  = 1'b0;
                high_next    = 1'b0;
                phase_next   = '0;
            end
        end

        res.line_level   = sending_next && high_next;
        res.busy_res     = sending_next;
        res.holder_free  = !held_valid_next;
        res.load_dropped = dropped;
        res.frame_done   = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_byte_reg  <= '0;
            held_valid_reg <= 1'b0;
            held_final_reg <= 1'b0;
            shift_reg      <= '0;
            bits_reg       <= '0;
            high_reg       <= 1'b0;
            phase_reg      <= '0;
            sending_reg    <= 1'b0;
            sfinal_reg     <= 1'b0;
        end
        else if (work_take)
        begin
            held_byte_reg  <= held_byte_next;
            held_valid_reg <= held_valid_next;
            held_final_reg <= held_final_next;
            shift_reg      <= shift_next;
            bits_reg       <= bits_next;
            high_reg       <= high_next;
            phase_reg      <= phase_next;
            sending_reg    <= sending_next;
            sfinal_reg     <= sfinal_next;
        end
    end

    always_comb
    begin
        out_cnt_next = out_cnt_reg;
        if (work_take && !out_pop)
        begin
            out_cnt_next = out_cnt_reg + 2'd1;
        end
        else if (out_pop && !work_take)
        begin
            out_cnt_next = out_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_cnt_reg <= 2'd0;
            out_wr_reg  <= 1'b0;
            out_rd_reg  <= 1'b0;
        end
        else
        begin
            out_cnt_reg <= out_cnt_next;
            if (work_take)
            begin
                out_wr_reg <= !out_wr_reg;
            end
            if (out_pop)
            begin
                out_rd_reg <= !out_rd_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (work_take)
        begin
            out_reg[out_wr_reg] <= res;
        end
    end

    assign result = out_reg[out_rd_reg];

    // A high phase only exists while a byte is being sent.
    `LCBS_ASSERT_SAME(a_high_needs_send, clk, rst_n, high_reg, sending_reg)
    // A running phase always has at least one tick left; idle holds none.
    `LCBS_ASSERT_SAME(a_phase_nonzero, clk, rst_n, sending_reg, phase_reg != '0)
    `LCBS_ASSERT_SAME(a_idle_phase_clear, clk, rst_n, !sending_reg, phase_reg == '0)
    // The result queue never overflows.
    `LCBS_ASSERT_NEXT(a_out_bound, clk, rst_n, out_cnt_reg == 2'd2 && !out_pop,
        out_cnt_reg == 2'd2)

endmodule

/* sv/led_chain_bit_serializer_unit.sv */
// Single-wire LED chain serializer. Each accepted beat is either a byte load
// into the one-byte holder or one timing tick, and each produces exactly one
// result beat showing the data line level, busy and holder state, a dropped-load
// flag and a frame-done pulse. One beat is accepted every clock cycle while
// the result queue has room or is being drained; each beat's result passes
// through the two-entry input queue, the waveform engine and the registered
// two-entry result queue. Bytes leave most significant bit
// first; phase lengths come from the fast timing registers or, in slow mode,
// from ticks_per_microsecond (one unit high, one unit low for a one and two
// for a zero). A zero phase length counts as one tick. Configuration should
// only be written while no beats are in flight.
module led_chain_bit_serializer_unit #(
    parameter int unsigned TIMING_BITS = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  lcbs_pkg::item_t                   item,
    output logic                              empty,
    input  logic                              pop,
    output lcbs_pkg::result_t                 result,
    input  logic                              cfg_write,
    input  logic [lcbs_pkg::CfgIndexBits-1:0] cfg_index,
    input  logic [TIMING_BITS-1:0]            cfg_data
);

    // The configuration registers hold timing in TIMING_BITS bits; the phase
    // counter is one bit wider so that two slow-mode units fit.
    logic                   speed_mode;
    logic [TIMING_BITS-1:0] fast_one_high;
    logic [TIMING_BITS-1:0] fast_one_low;
    logic [TIMING_BITS-1:0] fast_zero_high;
    logic [TIMING_BITS-1:0] fast_zero_low;
    logic [TIMING_BITS-1:0] ticks_per_us;

    lcbs_pkg::work_t        work;
    logic                   work_take;
    logic                   work_avail;

    lcbs_cfg #(
        .TIMING_BITS (TIMING_BITS)
    ) u_cfg (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .speed_mode     (speed_mode),
        .fast_one_high  (fast_one_high),
        .fast_one_low   (fast_one_low),
        .fast_zero_high (fast_zero_high),
        .fast_zero_low  (fast_zero_low),
        .ticks_per_us   (ticks_per_us)
    );

    // The front queue takes beats and tags them as load or tick.
    lcbs_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .work       (work),
        .work_take  (work_take),
        .work_avail (work_avail)
    );

    // The engine runs the holder, shifter and phase timer, one beat per cycle,
    // and stalls only when the result queue is full and not being drained.
    lcbs_back #(
        .TIMING_BITS (TIMING_BITS)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .work           (work),
        .work_avail     (work_avail),
        .work_take      (work_take),
        .speed_mode     (speed_mode),
        .fast_one_high  (fast_one_high),
        .fast_one_low   (fast_one_low),
        .fast_zero_high (fast_zero_high),
        .fast_zero_low  (fast_zero_low),
        .ticks_per_us   (ticks_per_us),
        .empty          (empty),
        .pop            (pop),
        .result         (result)
    );

endmodule

/* tb/tb_led_chain_bit_serializer_unit.sv */
`timescale 1ns / 100ps

module tb_led_chain_bit_serializer_unit;

    localparam int TB_TIMING_BITS = 10;
    // Slack allowed after the last result beat has come back.
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RESET_TIMING_TICKS = 416;
    localparam int RANDOM_BEATS = 540;
    localparam int RANDOM_SETTINGS = 6;
    localparam int MAX_REPORTS = 10;

    // Register indexes that map to nothing; writes there must be ignored.
    localparam logic [lcbs_pkg::CfgIndexBits-1:0] REG_SPARE_A = 3'd6;
    localparam logic [lcbs_pkg::CfgIndexBits-1:0] REG_SPARE_B = 3'd7;

    // Receiver stall patterns.
    localparam int RX_STEADY = 0;
    localparam int RX_MOSTLY = 1;
    localparam int RX_PERIODIC = 2;
    localparam int RX_SPARSE = 3;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              push;
    logic                              full;
    lcbs_pkg::item_t                   item_in;
    logic                              empty;
    logic                              pop = 1'b0;
    lcbs_pkg::result_t                 result_out;
    logic                              cfg_write;
    logic [lcbs_pkg::CfgIndexBits-1:0] cfg_index;
    logic [TB_TIMING_BITS-1:0]         cfg_data;

    // Shadow copy of the timing registers.
    logic                      fast_timing;
    logic [TB_TIMING_BITS-1:0] one_high_ticks;
    logic [TB_TIMING_BITS-1:0] one_low_ticks;
    logic [TB_TIMING_BITS-1:0] zero_high_ticks;
    logic [TB_TIMING_BITS-1:0] zero_low_ticks;
    logic [TB_TIMING_BITS-1:0] us_ticks;

    // Shadow copy of the holder and the bit shifter.
    logic [7:0]  holder_byte;
    logic        holder_full;
    logic        holder_last;
    logic [7:0]  out_byte;
    logic [2:0]  out_bits_left;
    logic        out_high;
    logic [10:0] out_ticks_left;
    logic        out_active;
    logic        out_last;

    // Line states predicted for accepted beats, oldest first.
    lcbs_pkg::result_t line_states_due[$];

    int failures = 0;
    int reports = 0;
    int beats_sent = 0;
    int loads_sent = 0;
    int loads_refused = 0;
    int frames_ended = 0;
    int results_checked = 0;
    int settings_applied = 0;
    int cycle_count = 0;

    // Sender pacing: bursts of random length separated by random gaps.
    bit pacing = 1'b0;
    int burst_left = 0;

    // Receiver pattern state and the long hold-off request.
    bit hold_req = 1'b0;
    int hold_left = 0;
    int rx_mode = RX_STEADY;
    int rx_mode_left = 0;
    int rx_phase = 0;

    led_chain_bit_serializer_unit #(
        .TIMING_BITS(TB_TIMING_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item_in),
        .empty     (empty),
        .pop       (pop),
        .result    (result_out),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Line encoder predictor
    // ------------------------------------------------------------------

    function automatic void reset_encoder_model();
        fast_timing = 1'b1;
        one_high_ticks = 10'd140;
        one_low_ticks = 10'd68;
        zero_high_ticks = 10'd68;
        zero_low_ticks = 10'd140;
        us_ticks = 10'd168;
        holder_byte = '0;
        holder_full = 1'b0;
        holder_last = 1'b0;
        out_byte = '0;
        out_bits_left = '0;
        out_high = 1'b0;
        out_ticks_left = '0;
        out_active = 1'b0;
        out_last = 1'b0;
    endfunction

    // Phase length in ticks. Slow mode works in microseconds: one unit high
    // for either bit, one unit low for a one and two for a zero. A length of
    // zero is stretched to a single tick.
    function automatic logic [10:0] phase_length(input logic high, input logic one);
        logic [10:0] n;
        if (fast_timing)
        begin
            if (high)
                n = 11'(one ? one_high_ticks : zero_high_ticks);
            else
                n = 11'(one ? one_low_ticks : zero_low_ticks);
        end
        else if (high || one)
        begin
            n = 11'(us_ticks);
        end
        else
        begin
            n = {us_ticks, 1'b0};
        end
        return (n == 11'd0) ? 11'd1 : n;
    endfunction

    function automatic logic current_bit();
        return |(out_byte & lcbs_pkg::MSB_MASK);
    endfunction

    // Move the held byte into the shifter and open the high phase of its MSB.
    function automatic void take_held_byte();
        out_byte = holder_byte;
        out_last = holder_last;
        holder_full = 1'b0;
        out_bits_left = lcbs_pkg::LAST_BIT_COUNT;
        out_active = 1'b1;
        out_high = 1'b1;
        out_ticks_left = phase_length(1'b1, current_bit());
    endfunction

    // Advance the shadow state by one beat and return the line state after it.
    function automatic lcbs_pkg::result_t predict_line_state(input lcbs_pkg::item_t it);
        lcbs_pkg::result_t r;
        logic              refused;
        logic              frame_end;
        refused = 1'b0;
        frame_end = 1'b0;
        if (it.kind == lcbs_pkg::KIND_LOAD)
        begin
            if (holder_full)
            begin
                refused = 1'b1;
            end
            else
            begin
                holder_byte = it.data_byte;
                holder_last = it.final_byte;
                holder_full = 1'b1;
            end
        end
        else if (!out_active)
        begin
            if (holder_full)
                take_held_byte();
        end
        else if (out_ticks_left > 11'd1)
        begin
            out_ticks_left = out_ticks_left - 11'd1;
        end
        else if (out_high)
        begin
            out_high = 1'b0;
            out_ticks_left = phase_length(1'b0, current_bit());
        end
        else if (out_bits_left != 3'd0)
        begin
            out_bits_left = out_bits_left - 3'd1;
            out_byte = out_byte << 1;
            out_high = 1'b1;
            out_ticks_left = phase_length(1'b1, current_bit());
        end
        else
        begin
            // Last bit of the byte is over; chain straight into a held byte.
            frame_end = out_last;
            if (holder_full)
            begin
                take_held_byte();
            end
            else
            begin
                out_active = 1'b0;
                out_last = 1'b0;
                out_high = 1'b0;
                out_ticks_left = '0;
            end
        end
        r.line_level = out_active && out_high;
        r.busy_res = out_active;
        r.holder_free = !holder_full;
        r.load_dropped = refused;
        r.frame_done = frame_end;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Beat construction
    // ------------------------------------------------------------------

    // Tick beats carry random data and frame bits, which the block ignores.
    function automatic lcbs_pkg::item_t make_tick();
        lcbs_pkg::item_t it;
        it.kind = lcbs_pkg::KIND_TICK;
        it.data_byte = 8'($urandom);
        it.final_byte = 1'($urandom);
        return it;
    endfunction

    function automatic lcbs_pkg::item_t make_load(input logic [7:0] b,
                                                  input logic last_of_frame);
        lcbs_pkg::item_t it;
        it.kind = lcbs_pkg::KIND_LOAD;
        it.data_byte = b;
        it.final_byte = last_of_frame;
        return it;
    endfunction

    // Mostly well-formed traffic: a load at the given percentage when the holder
    // has room, ticks otherwise, plus an occasional load into a full holder as noise.
    function automatic lcbs_pkg::item_t pick_beat(input int load_pct);
        lcbs_pkg::item_t it;
        it = make_tick();
        if (holder_full ? ($urandom_range(0, 99) < 8) : ($urandom_range(0, 99) < load_pct))
            it.kind = lcbs_pkg::KIND_LOAD;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Offer one beat and hold it until the block takes it. The push line is
    // left high, bar the gaps between paced bursts, so that back-to-back beats need no extra edge.
    task automatic send_beat(input lcbs_pkg::item_t it);
        lcbs_pkg::result_t due;
        push <= 1'b1;
        item_in <= it;
        @(posedge clk);
        while (full)
            @(posedge clk);
        due = predict_line_state(it);
        line_states_due.push_back(due);
        beats_sent++;
        if (it.kind == lcbs_pkg::KIND_LOAD)
            loads_sent++;
        if (due.load_dropped)
            loads_refused++;
        if (due.frame_done)
            frames_ended++;
        if (pacing)
        begin
            burst_left--;
            if (burst_left <= 0)
            begin
                push <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                burst_left = $urandom_range(1, 24);
            end
        end
    endtask

    // Tick until the shifter has finished and the holder is empty.
    task automatic run_line_idle();
        while (out_active || holder_full)
            send_beat(make_tick());
    endtask

    // Stop offering beats and wait for every predicted state to come back,
    // then let the block settle so that nothing is left inside it.
    task automatic wait_quiet();
        push <= 1'b0;
        while (line_states_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [lcbs_pkg::CfgIndexBits-1:0] idx,
                             input logic [TB_TIMING_BITS-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        case (idx)
            lcbs_pkg::REG_SPEED_MODE:     fast_timing = val[0];
            lcbs_pkg::REG_FAST_ONE_HIGH:  one_high_ticks = val;
            lcbs_pkg::REG_FAST_ONE_LOW:   one_low_ticks = val;
            lcbs_pkg::REG_FAST_ZERO_HIGH: zero_high_ticks = val;
            lcbs_pkg::REG_FAST_ZERO_LOW:  zero_low_ticks = val;
            lcbs_pkg::REG_TICKS_PER_US:   us_ticks = val;
            default: ;
        endcase
    endtask

    // Rewrite the whole register set once the block is quiet. The upper data
    // bits of the mode write are random, and one write goes to an unmapped
    // index, so both must leave the timing alone.
    task automatic apply_timing(input logic fast,
                                input logic [TB_TIMING_BITS-1:0] one_hi,
                                input logic [TB_TIMING_BITS-1:0] one_lo,
                                input logic [TB_TIMING_BITS-1:0] zero_hi,
                                input logic [TB_TIMING_BITS-1:0] zero_lo,
                                input logic [TB_TIMING_BITS-1:0] us);
        wait_quiet();
        write_reg(lcbs_pkg::REG_SPEED_MODE, {9'($urandom), fast});
        write_reg(lcbs_pkg::REG_FAST_ONE_HIGH, one_hi);
        write_reg(lcbs_pkg::REG_FAST_ONE_LOW, one_lo);
        write_reg(lcbs_pkg::REG_FAST_ZERO_HIGH, zero_hi);
        write_reg(lcbs_pkg::REG_FAST_ZERO_LOW, zero_lo);
        write_reg(lcbs_pkg::REG_TICKS_PER_US, us);
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 10'($urandom));
        cfg_write <= 1'b0;
        @(posedge clk);
        settings_applied++;
    endtask

    // ------------------------------------------------------------------
    // Receiver side: checks each popped beat and picks the next pop value.
    // ------------------------------------------------------------------

    task automatic check_line_state(input lcbs_pkg::result_t got);
        lcbs_pkg::result_t want;
        if (line_states_due.size() == 0)
        begin
            failures++;
            if (reports < MAX_REPORTS)
            begin
                reports++;
                $display("[%0d] result beat with nothing outstanding: %b", cycle_count, got);
            end
        end
        else
        begin
            want = line_states_due.pop_front();
            results_checked++;
            if (got.line_level !== want.line_level || got.busy_res !== want.busy_res ||
                got.holder_free !== want.holder_free ||
                got.load_dropped !== want.load_dropped ||
                got.frame_done !== want.frame_done)
            begin
                failures++;
                if (reports < MAX_REPORTS)
                begin
                    reports++;
                    $display("[%0d] result %0d mismatch: line %b/%b busy %b/%b free %b/%b",
                             cycle_count, results_checked, want.line_level, got.line_level,
                             want.busy_res, got.busy_res, want.holder_free,
                             got.holder_free);
                    $display("        dropped %b/%b frame_done %b/%b (expected/actual)",
                             want.load_dropped, got.load_dropped, want.frame_done,
                             got.frame_done);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            check_line_state(result_out);

        // A requested hold-off is counted here, independent of the sender.
        if (hold_req)
        begin
            hold_left = HOLD_OFF_CYCLES;
            hold_req = 1'b0;
        end

        if (rx_mode_left == 0)
        begin
            rx_mode = $urandom_range(RX_STEADY, RX_SPARSE);
            rx_mode_left = $urandom_range(50, 300);
        end
        else
        begin
            rx_mode_left--;
        end
        rx_phase++;

        if (hold_left != 0)
        begin
            hold_left--;
            pop <= 1'b0;
        end
        else
        begin
            case (rx_mode)
                RX_STEADY:   pop <= 1'b1;
                RX_MOSTLY:   pop <= ($urandom_range(0, 3) != 0);
                RX_PERIODIC: pop <= ((rx_phase % 3) != 0);
                default:     pop <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles, %0d results outstanding",
                     cycle_count, line_states_due.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset timing: a byte with a leading one runs through the high and low
    // phases of its first two bits, which covers all four fast registers at
    // their reset lengths. Short timing is then written while the byte is
    // still going, so only the phases that start afterwards see it.
    task automatic test_reset_timing();
        send_beat(make_load(8'h80, 1'b1));
        repeat (RESET_TIMING_TICKS) send_beat(make_tick());
        apply_timing(1'b1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1);
        run_line_idle();
    endtask

    // Short directed sequence on one-tick phases: a tick with nothing to
    // send, loads into a full holder both before and during sending, a frame
    // end followed directly by another byte, then slow mode with a zero
    // microsecond length.
    task automatic test_directed_cases();
        apply_timing(1'b1, 10'd0, 10'd0, 10'd0, 10'd0, 10'd1);
        send_beat(make_tick());
        send_beat(make_load(8'hA5, 1'b1));
        send_beat(make_load(8'h5A, 1'b0));
        send_beat(make_tick());
        send_beat(make_load(8'h00, 1'b0));
        send_beat(make_load(8'hFF, 1'b1));
        run_line_idle();
        apply_timing(1'b0, 10'd3, 10'd3, 10'd3, 10'd3, 10'd0);
        send_beat(make_load(8'h81, 1'b1));
        run_line_idle();
    endtask

    // Random traffic under several random timing sets. Lengths stay small so
    // that many bytes and frames complete; the load rate varies so that the
    // line both streams without gaps and falls idle now and then.
    task automatic test_random_settings();
        int span;
        int load_pct;
        for (int k = 0; k < RANDOM_SETTINGS; k++)
        begin
            span = (k == RANDOM_SETTINGS - 1) ? 24 : 4;
            apply_timing(($urandom_range(0, 2) != 0),
                         10'($urandom_range(0, span)), 10'($urandom_range(0, span)),
                         10'($urandom_range(0, span)), 10'($urandom_range(0, span)),
                         10'($urandom_range(0, 3)));
            pacing = (k % 3 != 0);
            burst_left = $urandom_range(1, 24);
            case ($urandom_range(0, 2))
                0:       load_pct = 5;
                1:       load_pct = 20;
                default: load_pct = 45;
            endcase
            repeat (RANDOM_BEATS / RANDOM_SETTINGS) send_beat(pick_beat(load_pct));
        end
        pacing = 1'b0;
    endtask

    // The receiver stops for a long stretch while beats keep coming, so the
    // block fills and holds off its input; then the sender waits for every
    // result before a last paced burst.
    task automatic test_backpressure();
        apply_timing(1'b1, 10'd1, 10'd0, 10'd0, 10'd1, 10'd2);
        hold_req = 1'b1;
        repeat (60) send_beat(pick_beat(30));
        wait_quiet();
        pacing = 1'b1;
        burst_left = $urandom_range(1, 24);
        repeat (20) send_beat(pick_beat(30));
        pacing = 1'b0;
        run_line_idle();
    endtask

    initial
    begin
        rst_n <= 1'b0;
        push <= 1'b0;
        item_in <= '0;
        cfg_write <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        reset_encoder_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_timing();
        test_directed_cases();
        test_random_settings();
        test_backpressure();

        wait_quiet();
        repeat (2 * SETTLE_CYCLES) @(posedge clk);
        if (line_states_due.size() != 0)
        begin
            failures++;
            $display("%0d predicted results never arrived", line_states_due.size());
        end

        $display("Sent %0d beats (%0d byte loads, %0d refused by a full holder)",
                 beats_sent, loads_sent, loads_refused);
        $display("under %0d timing sets; checked %0d line states, %0d frame ends, %0d failures",
                 settings_applied, results_checked, frames_ended, failures);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
